// File: src/bmse_pkg.sv
// ----------------------------------------------------------------------------
// bmse_pkg
// Shared types, register indexes and sizing helpers of the bitmap span extractor.
// ----------------------------------------------------------------------------
package bmse_pkg;

   // word widths on the ports
   localparam int PIX_W       = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // compare width for clamping size registers against the size limits
   localparam int LIMIT_W = 13;

   // entries of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // span end positions per byte (eight pixels plus end of row) and start flags
   localparam int ENDS_W   = 9;
   localparam int STARTS_W = 8;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_X     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_Y     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_INK_COLOR    = 3'd4;

   // configuration register file
   typedef struct packed {
      logic signed [14:0] origin_x;
      logic signed [14:0] origin_y;
      logic        [10:0] image_width;
      logic        [10:0] image_height;
      logic        [15:0] ink_color;
   } cfg_type;

   // width of one queued byte record: ends, starts, carried start, base column, row
   function automatic int rec_width(input int col_w, input int row_w);
      return ENDS_W + STARTS_W + 2 * col_w + row_w;
   endfunction

endpackage

// File: src/bmse_queue.sv
// ----------------------------------------------------------------------------
// bmse_queue
// Small flip-flop queue that decouples byte classification from span output.
// ----------------------------------------------------------------------------
module bmse_queue #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/bmse_front.sv
// ----------------------------------------------------------------------------
// bmse_front
// Tracks column, row and open run per byte and marks where spans start and end.
// ----------------------------------------------------------------------------
module bmse_front #(
   parameter int WIDTH_CAP  = 1024,
   parameter int HEIGHT_CAP = 1024,
   parameter int COL_W      = 11,
   parameter int ROW_W      = 11
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     restart,
   input  bmse_pkg::cfg_type                        cfg,
   input  logic                                     accept,
   input  logic [bmse_pkg::PIX_W-1:0]               pixel_byte,
   output logic                                     rec_push,
   output logic [bmse_pkg::rec_width(COL_W, ROW_W)-1:0] rec_data
);

   localparam int BC_W = COL_W - 3;

   logic [BC_W-1:0]  byte_col_ff, byte_col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             open_ff, open_in;
   logic [COL_W-1:0] start_ff, start_in;

   logic [bmse_pkg::LIMIT_W-1:0]  wide_width, wide_height;
   logic [COL_W-1:0]              width_eff, base, remain, start_new;
   logic [ROW_W-1:0]              height_eff;
   logic                          active, eor, advance;
   logic [3:0]                    nv;
   logic [bmse_pkg::ENDS_W-1:0]   on, prev, ends;
   logic [bmse_pkg::STARTS_W-1:0] starts;

   // clamp the size registers to the size limits
   always_comb begin
      wide_width  = bmse_pkg::LIMIT_W'(cfg.image_width);
      wide_height = bmse_pkg::LIMIT_W'(cfg.image_height);
      width_eff   = (wide_width > bmse_pkg::LIMIT_W'(WIDTH_CAP)) ?
                    COL_W'(WIDTH_CAP) : COL_W'(wide_width);
      height_eff  = (wide_height > bmse_pkg::LIMIT_W'(HEIGHT_CAP)) ?
                    ROW_W'(HEIGHT_CAP) : ROW_W'(wide_height);
      active      = (width_eff != '0) && (height_eff != '0) && (row_ff < height_eff);
   end

   // pixels of this byte inside the row and run boundaries
   always_comb begin
      base   = {byte_col_ff, 3'b000};
      remain = width_eff - base;
      eor    = (remain <= COL_W'(8));
      nv     = eor ? remain[3:0] : 4'd8;
      on     = '0;
      for (int i = 0; i < 8; i++) begin
         on[i] = pixel_byte[7 - i] && (4'(i) < nv);
      end
      prev[0] = open_ff;
      for (int i = 1; i < bmse_pkg::ENDS_W; i++) begin
         prev[i] = on[i - 1];
      end
      for (int p = 0; p < bmse_pkg::ENDS_W; p++) begin
         ends[p] = ((4'(p) < nv) && !on[p] && prev[p]) || (eor && (4'(p) == nv) && prev[p]);
      end
      for (int i = 0; i < bmse_pkg::STARTS_W; i++) begin
         starts[i] = on[i] && !prev[i];
      end
      // last run opened in this byte wins
      start_new = start_ff;
      for (int i = 0; i < bmse_pkg::STARTS_W; i++) begin
         if (starts[i]) begin
            start_new = base + COL_W'(i);
         end
      end
   end

   // scan state update
   always_comb begin
      advance     = accept && active;
      byte_col_in = byte_col_ff;
      row_in      = row_ff;
      open_in     = open_ff;
      start_in    = start_ff;
      if (advance) begin
         byte_col_in = eor ? '0 : byte_col_ff + 1'b1;
         row_in      = eor ? row_ff + 1'b1 : row_ff;
         open_in     = eor ? 1'b0 : on[7];
         start_in    = start_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         byte_col_ff <= '0;
         row_ff      <= '0;
         open_ff     <= 1'b0;
         start_ff    <= '0;
      end else begin
         byte_col_ff <= byte_col_in;
         row_ff      <= row_in;
         open_ff     <= open_in;
         start_ff    <= start_in;
      end
   end

   // only bytes that close at least one span go to the queue
   assign rec_push = advance && (ends != '0);
   assign rec_data = {ends, starts, start_ff, base, row_ff};

endmodule

// File: src/bmse_back.sv
// ----------------------------------------------------------------------------
// bmse_back
// Walks head record span ends to output stage, one span per cycle while it is free.
// ----------------------------------------------------------------------------
module bmse_back #(
   parameter int COL_W = 11,
   parameter int ROW_W = 11
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  bmse_pkg::cfg_type                            cfg,
   input  logic                                         q_valid,
   input  logic [bmse_pkg::rec_width(COL_W, ROW_W)-1:0] q_data,
   output logic                                         q_pop,
   output logic                                         rsp_empty,
   input  logic                                         rsp_pop,
   output logic signed [15:0]                           rsp_span_x,
   output logic signed [15:0]                           rsp_span_y,
   output logic [10:0]                                  rsp_span_length,
   output logic [15:0]                                  rsp_span_ink,
   output logic                                         rsp_last_of_item
);

   localparam int REC_W = bmse_pkg::rec_width(COL_W, ROW_W);

   logic [bmse_pkg::ENDS_W-1:0]   ends, live, sel;
   logic [bmse_pkg::ENDS_W-1:0]   done_ff, done_in;
   logic [bmse_pkg::STARTS_W-1:0] starts;
   logic [COL_W-1:0]              carry_start, base, start_col;
   logic [ROW_W-1:0]              row;
   logic [3:0]                    p;
   logic [2:0]                    sidx;
   logic                          found, last, slot_free, step;
   logic [15:0]                   x, y, end_col, len;

   logic                out_valid_ff, out_valid_in;
   logic signed [15:0]  x_ff, y_ff;
   logic [10:0]         len_ff;
   logic [15:0]         ink_ff;
   logic                last_ff;

   // unpack the head record
   assign ends        = q_data[REC_W-1 -: bmse_pkg::ENDS_W];
   assign starts      = q_data[REC_W-bmse_pkg::ENDS_W-1 -: bmse_pkg::STARTS_W];
   assign carry_start = q_data[ROW_W+2*COL_W-1 -: COL_W];
   assign base        = q_data[ROW_W+COL_W-1 -: COL_W];
   assign row         = q_data[ROW_W-1:0];

   // next span: lowest open end, and the latest start before it
   always_comb begin
      live = ends & ~done_ff;
      p    = 4'd0;
      for (int i = bmse_pkg::ENDS_W - 1; i >= 0; i--) begin
         if (live[i]) begin
            p = 4'(i);
         end
      end
      sel   = bmse_pkg::ENDS_W'(1) << p;
      last  = ((live & ~sel) == '0);
      found = 1'b0;
      sidx  = 3'd0;
      for (int i = 0; i < bmse_pkg::STARTS_W; i++) begin
         if (starts[i] && (4'(i) < p)) begin
            found = 1'b1;
            sidx  = 3'(i);
         end
      end
      start_col = found ? base + COL_W'(sidx) : carry_start;
      end_col   = 16'(base) + 16'(p);
      len       = end_col - 16'(start_col);
      x         = {cfg.origin_x[14], cfg.origin_x} + 16'(start_col);
      y         = {cfg.origin_y[14], cfg.origin_y} + 16'(row);
   end

   // advance when the output stage is free or being drained
   always_comb begin
      slot_free    = !out_valid_ff || rsp_pop;
      step         = q_valid && slot_free;
      q_pop        = step && last;
      done_in      = done_ff;
      out_valid_in = out_valid_ff;
      if (step) begin
         done_in      = last ? '0 : (done_ff | sel);
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (step) begin
         x_ff    <= x;
         y_ff    <= y;
         len_ff  <= len[10:0];
         ink_ff  <= cfg.ink_color;
         last_ff <= last;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_span_x       = x_ff;
   assign rsp_span_y       = y_ff;
   assign rsp_span_length  = len_ff;
   assign rsp_span_ink     = ink_ff;
   assign rsp_last_of_item = last_ff;

endmodule

// File: src/bitmap_row_span_extractor.sv
// ----------------------------------------------------------------------------
// bitmap_row_span_extractor
// Turns a byte stream of a one-bit bitmap into horizontal ink spans per row.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while each byte closes at most one span and the
//   receiver keeps popping; a byte that closes several spans (up to five) hands
//   them out one at a time, absorbed by a four-entry queue between the byte
//   scanner and the span walker; spans pass the queue and the output register.
//   Reset zeroes the registers and scan state, empties queue and output.
module bitmap_row_span_extractor #(
   parameter int WIDTH_CAP  = 1024,
   parameter int HEIGHT_CAP = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [bmse_pkg::PIX_W-1:0]          req_pixel_byte,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [15:0]                  rsp_span_x,
   output logic signed [15:0]                  rsp_span_y,
   output logic [10:0]                         rsp_span_length,
   output logic [15:0]                         rsp_span_ink,
   output logic                                rsp_last_of_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bmse_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bmse_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int COL_W = $clog2(WIDTH_CAP + 1);
   localparam int ROW_W = $clog2(HEIGHT_CAP + 1);
   localparam int REC_W = bmse_pkg::rec_width(COL_W, ROW_W);

   bmse_pkg::cfg_type cfg_ff, cfg_in;
   logic              restart;
   logic              accept;
   logic              q_push, q_full, q_valid, q_pop;
   logic [REC_W-1:0]  q_push_data, q_pop_data;

   // configuration register writes; a known register restarts the image
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in  = cfg_ff;
      restart = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            bmse_pkg::REG_ORIGIN_X: begin
               cfg_in.origin_x = csr_data[14:0];
               restart         = 1'b1;
            end
            bmse_pkg::REG_ORIGIN_Y: begin
               cfg_in.origin_y = csr_data[14:0];
               restart         = 1'b1;
            end
            bmse_pkg::REG_IMAGE_WIDTH: begin
               cfg_in.image_width = csr_data[10:0];
               restart            = 1'b1;
            end
            bmse_pkg::REG_IMAGE_HEIGHT: begin
               cfg_in.image_height = csr_data[10:0];
               restart             = 1'b1;
            end
            bmse_pkg::REG_INK_COLOR: begin
               cfg_in.ink_color = csr_data;
               restart          = 1'b1;
            end
            default: begin
               cfg_in  = cfg_ff;
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input word handshake
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // byte scanner
   bmse_front #(
      .WIDTH_CAP  (WIDTH_CAP),
      .HEIGHT_CAP (HEIGHT_CAP),
      .COL_W      (COL_W),
      .ROW_W      (ROW_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .cfg        (cfg_ff),
      .accept     (accept),
      .pixel_byte (req_pixel_byte),
      .rec_push   (q_push),
      .rec_data   (q_push_data)
   );

   // record queue
   bmse_queue #(
      .WIDTH (REC_W),
      .DEPTH (bmse_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_pop_data)
   );

   // span walker and output stage
   bmse_back #(
      .COL_W (COL_W),
      .ROW_W (ROW_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_valid          (q_valid),
      .q_data           (q_pop_data),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_span_x       (rsp_span_x),
      .rsp_span_y       (rsp_span_y),
      .rsp_span_length  (rsp_span_length),
      .rsp_span_ink     (rsp_span_ink),
      .rsp_last_of_item (rsp_last_of_item)
   );

   // queued records always carry at least one span end
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_push_data[REC_W-1 -: bmse_pkg::ENDS_W] != '0))
      else $error("record queued without any span end");

   // retiring a record leaves its final span in the output stage
   assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (!rsp_empty && rsp_last_of_item))
      else $error("record retired without a final span");

   // a span only appears when a record was waiting
   assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_empty) |-> $past(q_valid))
      else $error("span shown without a queued record");

endmodule

// File: test/tb_bitmap_row_span_extractor.sv
// ----------------------------------------------------------------------------
// tb_bitmap_row_span_extractor
// Feeds bitmap bytes and register settings to the span extractor, predicts
// every ink span in a scoreboard and checks each popped span word against it.
// ----------------------------------------------------------------------------
module tb_bitmap_row_span_extractor;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W         = 1024;
   localparam int MAX_H         = 1024;
   localparam int IDLE_LIMIT    = 5000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_BYTES  = 180;

   // one expected or observed span word
   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [10:0]        length;
      logic [15:0]        ink;
      logic               last;
   } span_type;

   // span prediction and comparison
   class span_tracker_type;
      logic signed [14:0] origin_x;
      logic signed [14:0] origin_y;
      logic [10:0]        width_reg;
      logic [10:0]        height_reg;
      logic [15:0]        ink;
      int unsigned        byte_col;
      int unsigned        row;
      int unsigned        run_from;
      bit                 run_on;
      span_type           expected_spans[$];
      int unsigned        errors;

      function new();
         origin_x   = '0;
         origin_y   = '0;
         width_reg  = '0;
         height_reg = '0;
         ink        = '0;
         errors     = 0;
         restart();
      endfunction

      function void restart();
         byte_col = 0;
         row      = 0;
         run_on   = 1'b0;
         run_from = 0;
      endfunction

      // register write; unused indexes leave the image untouched
      function void write_reg(logic [bmse_pkg::CSR_INDEX_W-1:0] idx,
                              logic [bmse_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            bmse_pkg::REG_ORIGIN_X:     origin_x   = data[14:0];
            bmse_pkg::REG_ORIGIN_Y:     origin_y   = data[14:0];
            bmse_pkg::REG_IMAGE_WIDTH:  width_reg  = data[10:0];
            bmse_pkg::REG_IMAGE_HEIGHT: height_reg = data[10:0];
            bmse_pkg::REG_INK_COLOR:    ink        = data;
            default:                    return;
         endcase
         restart();
      endfunction

      function void close_run(int unsigned end_col);
         span_type s;
         s.x      = {origin_x[14], origin_x} + 16'(run_from);
         s.y      = {origin_y[14], origin_y} + 16'(row);
         s.length = 11'(end_col - run_from);
         s.ink    = ink;
         s.last   = 1'b0;
         expected_spans.push_back(s);
         run_on = 1'b0;
      endfunction

      // note one accepted pixel byte
      function void take_byte(logic [7:0] pix);
         int unsigned w;
         int unsigned h;
         int unsigned base;
         int unsigned col;
         int unsigned queued;
         w = (width_reg > MAX_W) ? MAX_W : width_reg;
         h = (height_reg > MAX_H) ? MAX_H : height_reg;
         if (w == 0 || h == 0 || row >= h) return;
         queued = expected_spans.size();
         base   = byte_col * 8;
         for (int i = 0; i < 8; i++) begin
            col = base + i;
            if (col >= w) break;
            if (pix[7-i]) begin
               if (!run_on) begin
                  run_on   = 1'b1;
                  run_from = col;
               end
            end else if (run_on) begin
               close_run(col);
            end
         end
         // end of row closes an open run, padding bits never count
         if (base + 8 >= w) begin
            if (run_on) close_run(w);
            byte_col = 0;
            row++;
         end else begin
            byte_col++;
         end
         if (expected_spans.size() > queued)
            expected_spans[expected_spans.size()-1].last = 1'b1;
      endfunction

      function void note(string field, int exp_v, int act_v);
         if (exp_v != act_v) begin
            errors++;
            $display("%0t ns: span %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_v, act_v);
         end
      endfunction

      // compare one popped span word with the oldest prediction
      function void check_span(span_type got);
         span_type want;
         if (expected_spans.size() == 0) begin
            errors++;
            $display("%0t ns: span with none expected, actual x=%0d y=%0d",
                     $time, got.x, got.y);
            $display("   length=%0d ink=%0d last=%0d", got.length, got.ink, got.last);
            return;
         end
         want = expected_spans.pop_front();
         note("x", want.x, got.x);
         note("y", want.y, got.y);
         note("length", want.length, got.length);
         note("ink", want.ink, got.ink);
         note("last", want.last, got.last);
      endfunction
   endclass

   logic                             clock          = 1'b0;
   logic                             reset          = 1'b1;
   logic                             req_push       = 1'b0;
   logic                             req_full;
   logic [bmse_pkg::PIX_W-1:0]       req_pixel_byte = '0;
   logic                             rsp_empty;
   logic                             rsp_pop        = 1'b0;
   logic signed [15:0]               rsp_span_x;
   logic signed [15:0]               rsp_span_y;
   logic [10:0]                      rsp_span_length;
   logic [15:0]                      rsp_span_ink;
   logic                             rsp_last_of_item;
   logic                             csr_valid      = 1'b0;
   logic                             csr_ready;
   logic [bmse_pkg::CSR_INDEX_W-1:0] csr_index      = '0;
   logic [bmse_pkg::CSR_DATA_W-1:0]  csr_data       = '0;

   span_tracker_type tracker = new();
   bit               tx_steady = 1'b0;
   bit               rx_steady = 1'b0;
   int unsigned      pop_wait = 0;
   int unsigned      idle_cycles = 0;

   bitmap_row_span_extractor #(
      .WIDTH_CAP  (MAX_W),
      .HEIGHT_CAP (MAX_H)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_pixel_byte   (req_pixel_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_span_x       (rsp_span_x),
      .rsp_span_y       (rsp_span_y),
      .rsp_span_length  (rsp_span_length),
      .rsp_span_ink     (rsp_span_ink),
      .rsp_last_of_item (rsp_last_of_item),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // gap length: mostly none or short, now and then long
   function automatic int unsigned pick_gap(bit steady);
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   // receiver with random stalls
   always @(posedge clock) begin
      if (rsp_pop && !rsp_empty)
         pop_wait = pick_gap(rx_steady);
      else if (pop_wait == 0 && $urandom_range(15) == 0)
         pop_wait = pick_gap(rx_steady);
      if (pop_wait > 0) begin
         rsp_pop <= 1'b0;
         pop_wait = pop_wait - 1;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // check every popped span word
   always @(posedge clock) begin : span_check
      span_type got;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.x      = rsp_span_x;
         got.y      = rsp_span_y;
         got.length = rsp_span_length;
         got.ink    = rsp_span_ink;
         got.last   = rsp_last_of_item;
         tracker.check_span(got);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // push one pixel byte, then maybe idle
   task automatic send_byte(input logic [7:0] pix);
      int unsigned gap;
      req_push       <= 1'b1;
      req_pixel_byte <= pix;
      do @(posedge clock); while (req_full);
      tracker.take_byte(pix);
      gap = pick_gap(tx_steady);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending and wait for every predicted span to drain
   task automatic settle(input int unsigned extra);
      req_push <= 1'b0;
      @(posedge clock);
      while (tracker.expected_spans.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input logic [bmse_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [bmse_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, data);
   endtask

   task automatic end_writes();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // write all registers in random order, upper data bits random
   task automatic set_image(input logic signed [14:0] ox, input logic signed [14:0] oy,
                            input logic [10:0] w, input logic [10:0] h,
                            input logic [15:0] ink_value, input bit junk);
      logic [bmse_pkg::CSR_INDEX_W-1:0] order[6];
      logic [bmse_pkg::CSR_INDEX_W-1:0] t;
      logic [bmse_pkg::CSR_DATA_W-1:0]  data;
      int unsigned                      n;
      int unsigned                      k;
      order = '{bmse_pkg::REG_ORIGIN_X, bmse_pkg::REG_ORIGIN_Y,
                bmse_pkg::REG_IMAGE_WIDTH, bmse_pkg::REG_IMAGE_HEIGHT,
                bmse_pkg::REG_INK_COLOR,
                bmse_pkg::REG_INK_COLOR + 3'($urandom_range(1, 3))};
      n = junk ? 6 : 5;
      for (int j = n - 1; j > 0; j--) begin
         k        = $urandom_range(j);
         t        = order[j];
         order[j] = order[k];
         order[k] = t;
      end
      settle(SETTLE_CYCLES);
      for (int i = 0; i < n; i++) begin
         case (order[i])
            bmse_pkg::REG_ORIGIN_X:     data = {1'($urandom_range(1)), ox};
            bmse_pkg::REG_ORIGIN_Y:     data = {1'($urandom_range(1)), oy};
            bmse_pkg::REG_IMAGE_WIDTH:  data = {5'($urandom), w};
            bmse_pkg::REG_IMAGE_HEIGHT: data = {5'($urandom), h};
            bmse_pkg::REG_INK_COLOR:    data = ink_value;
            default:                    data = 16'($urandom);
         endcase
         write_reg(order[i], data);
      end
      end_writes();
   endtask

   initial begin : stimulus
      int unsigned       rand_bytes;
      int unsigned       r;
      int unsigned       w;
      int unsigned       h;
      int unsigned       full_bytes;
      int unsigned       n_bytes;
      logic signed [14:0] ox;
      logic signed [14:0] oy;
      logic [7:0]        pix;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at reset give a zero-size image
      send_byte(8'hFF);
      send_byte(8'h00);

      // origin extremes, five spans from one byte, run across bytes, image done
      set_image(15'h4000, 15'h3FFF, 11'd16, 11'd2, 16'hFFFF, 1'b0);
      send_byte(8'h01);
      send_byte(8'h55);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h80);

      // padded rows; unused register indexes written mid-row change nothing
      set_image(15'h3FFF, 15'h4000, 11'd13, 11'd3, 16'h0000, 1'b0);
      send_byte(8'hAA);
      send_byte(8'h55);
      send_byte(8'hFF);
      settle(SETTLE_CYCLES);
      write_reg(bmse_pkg::REG_INK_COLOR + 3'd1, 16'hFFFF);
      write_reg(bmse_pkg::REG_INK_COLOR + 3'd2, 16'h0000);
      write_reg(bmse_pkg::REG_INK_COLOR + 3'd3, 16'h5A5A);
      end_writes();
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h07);

      // register write with a run open restarts the image
      set_image(15'h0000, 15'h0000, 11'd24, 11'd2, 16'h1234, 1'b0);
      send_byte(8'hFF);
      set_image(15'h0064, 15'h7FF6, 11'd8, 11'd1, 16'h8001, 1'b1);
      send_byte(8'h3C);

      // zero height, then zero width
      set_image(15'h0005, 15'h0005, 11'd8, 11'd0, 16'h0001, 1'b0);
      send_byte(8'hFF);
      set_image(15'h0005, 15'h0005, 11'd0, 11'd4, 16'h0001, 1'b0);
      send_byte(8'hFF);

      // width above the limit: one full row of ink at the right edge of x
      set_image(15'h3FFF, 15'h0000, 11'h7FF, 11'd1, 16'hA5A5, 1'b0);
      repeat (130) send_byte(8'hFF);

      // height register above the limit with one-pixel rows
      set_image(15'h4000, 15'h3FFF, 11'd1, 11'h7FF, 16'h5A5A, 1'b0);
      repeat (20) send_byte(8'($urandom));

      // random images
      rand_bytes = 0;
      while (rand_bytes < RANDOM_BYTES) begin
         tx_steady = ($urandom_range(4) == 0);
         rx_steady = ($urandom_range(4) == 0);
         r = $urandom_range(99);
         if (r < 5) w = 0;
         else if (r < 74) w = $urandom_range(1, 40);
         else if (r < 94) w = $urandom_range(41, 200);
         else if (r < 98) w = $urandom_range(201, 1024);
         else w = $urandom_range(1025, 2047);
         r = $urandom_range(99);
         if (r < 5) h = 0;
         else if (w > 200) h = 1;
         else if (r < 85) h = $urandom_range(1, 6);
         else h = $urandom_range(7, 16);
         ox = 15'($urandom);
         oy = 15'($urandom);
         r  = $urandom_range(9);
         if (r == 0) begin
            ox = 15'h4000;
            oy = 15'h3FFF;
         end else if (r == 1) begin
            ox = 15'h3FFF;
            oy = 15'h4000;
         end
         set_image(ox, oy, 11'(w), 11'(h), 16'($urandom), $urandom_range(6) == 0);
         full_bytes = (((w > MAX_W) ? MAX_W : w) + 7) / 8 * ((h > MAX_H) ? MAX_H : h);
         if (full_bytes == 0) n_bytes = $urandom_range(1, 3);
         else if ($urandom_range(4) == 0) n_bytes = $urandom_range(1, full_bytes);
         else n_bytes = full_bytes + $urandom_range(0, 2);
         for (int b = 0; b < n_bytes; b++) begin
            r = $urandom_range(9);
            if (r < 4) pix = 8'($urandom);
            else if (r < 6) pix = 8'($urandom & $urandom & $urandom);
            else if (r < 8) pix = 8'($urandom | $urandom);
            else if (r == 8) pix = $urandom_range(1) ? 8'hFF : 8'h00;
            else pix = $urandom_range(1) ? 8'h55 : 8'hAA;
            send_byte(pix);
            if (b < full_bytes) rand_bytes++;
            // now and then hold off until every span is out
            if ($urandom_range(49) == 0) settle(0);
         end
      end

      settle(SETTLE_CYCLES + 8);
      if (tracker.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: bitmap_row_span_extractor.f
src/bmse_pkg.sv
src/bmse_queue.sv
src/bmse_front.sv
src/bmse_back.sv
src/bitmap_row_span_extractor.sv
test/tb_bitmap_row_span_extractor.sv
